[hw/rtl/scs_pkg.sv]
// Shared types, constants and arithmetic helpers of the sensor channel supervisor.
package scs_pkg;

    // Tolerances and filter gain.
    localparam int MAX_RETRIES      = 3;
    localparam int MAX_BAD_SAMPLES  = 3;
    localparam int STABLE_THRESHOLD = 5;
    localparam int EMA_ALPHA        = 51;

    localparam logic [2:0] MAX_RETRIES_C     = 3'(MAX_RETRIES);
    localparam logic [2:0] MAX_BAD_SAMPLES_C = 3'(MAX_BAD_SAMPLES);
    localparam logic [3:0] STABLE_C          = 4'(STABLE_THRESHOLD);
    localparam logic [8:0] EMA_ALPHA_C       = 9'(EMA_ALPHA);

    // Difference is 17 bits signed, gain is up to 9 bits unsigned.
    localparam int PROD_W = 27;

    // Stream widths.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_LOW   = 3'd0,
        CFG_TEMP_HIGH  = 3'd1,
        CFG_HUM_LOW    = 3'd2,
        CFG_HUM_HIGH   = 3'd3,
        CFG_PROBE_INTV = 3'd4,
        CFG_DEAD_INTV  = 3'd5,
        CFG_TEMP_OFS   = 3'd6,
        CFG_HUM_OFS    = 3'd7
    } t_cfg_idx;

    // Configuration reset values.
    localparam logic signed [14:0] TEMP_LOW_RST   = -15'sd4000;
    localparam logic signed [14:0] TEMP_HIGH_RST  = 15'sd8500;
    localparam logic [13:0]        HUM_LOW_RST    = 14'd0;
    localparam logic [13:0]        HUM_HIGH_RST   = 14'd10000;
    localparam logic [31:0]        PROBE_INTV_RST = 32'd5000;
    localparam logic [31:0]        DEAD_INTV_RST  = 32'd3600000;
    localparam logic signed [11:0] OFS_RST        = 12'sd0;

    typedef struct packed {
        logic signed [14:0] temp_low;
        logic signed [14:0] temp_high;
        logic [13:0]        hum_low;
        logic [13:0]        hum_high;
        logic [31:0]        probe_intv;
        logic [31:0]        dead_intv;
        logic signed [11:0] temp_ofs;
        logic signed [11:0] hum_ofs;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               probe_ok;
        logic               sample_nan;
        logic signed [15:0] temp_sample;
        logic signed [15:0] raw_hum;
    } t_item;

    typedef struct packed {
        logic               sensor_ok;
        logic               data_valid;
        logic signed [15:0] temp_out;
        logic signed [15:0] hum_out;
        logic               stable;
        logic               responded;
        logic               probed;
        logic               budget_spent;
    } t_result;

    typedef struct packed {
        logic               present;
        logic [2:0]         retry_count;
        logic [31:0]        last_probe_time;
        logic [31:0]        last_grant_time;
        logic [2:0]         bad_count;
        logic [3:0]         stab_count;
        logic               primed;
        logic signed [15:0] filt_temp;
        logic signed [15:0] filt_hum;
        logic               valid;
        logic signed [15:0] held_temp;
        logic signed [15:0] held_hum;
    } t_state;

    // One EMA step: f + floor(alpha * (x - f) / 256). The result lies between f and x,
    // so the 16-bit wrap of the final add is exact.
    function automatic logic signed [15:0] f_ema(input logic signed [15:0] f,
                                                 input logic signed [15:0] x);
        logic signed [16:0]        diff;
        logic signed [PROD_W-1:0]  prod;
        logic signed [PROD_W-9:0]  step;
        diff = $signed({x[15], x}) - $signed({f[15], f});
        prod = diff * $signed({1'b0, EMA_ALPHA_C});
        step = (PROD_W-8)'(prod >>> 8);
        return f + step[15:0];
    endfunction

    // Clamp a 17-bit signed sum to the 16-bit signed range.
    function automatic logic signed [15:0] f_sat16(input logic signed [16:0] v);
        logic signed [15:0] res;
        if (v[16] != v[15]) begin
            res = v[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Filtered value plus a 12-bit calibration offset, saturated.
    function automatic logic signed [15:0] f_add_ofs(input logic signed [15:0] f,
                                                     input logic signed [11:0] ofs);
        logic signed [16:0] sum;
        sum = $signed({f[15], f}) + $signed({{5{ofs[11]}}, ofs});
        return f_sat16(sum);
    endfunction

endpackage

[hw/rtl/sensor_channel_supervisor.sv]
// Top level of the sensor channel supervisor: stream ports, pipeline registers and state.
//
// The block supervises one temperature and humidity sensor, one transaction per sensor
// update. A sensor marked failed is re-probed whenever probe_interval_ms has passed since
// the last probe, up to MAX_RETRIES times; after that a fresh retry budget is granted once
// dead_interval_ms has passed since the last grant. Samples of a present sensor are checked
// for NaN and against the configured limits; MAX_BAD_SAMPLES bad samples in a row drop the
// sensor. Good samples go through a primed exponential filter with a gain of EMA_ALPHA/256,
// then get the calibration offsets added with saturation to 16 bits. The block takes one
// transaction per clock cycle while the downstream side drains the output register: the
// input register feeds combinational next-state logic that writes the state and the output
// register together, so a result passes through the input register and then the output
// register, and the input side keeps accepting while a result waits in the output register
// as long as the downstream side drains it. Configuration writes take effect at the next
// edge and should be made while no transaction is in flight.
module sensor_channel_supervisor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata from bit 0: now_ms[31:0], probe_ok, temp_sample[15:0], raw_hum[15:0], zero fill.
    input  logic [scs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser: sample_nan.
    input  logic                              i_s_tuser,
    // Output stream.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata from bit 0: sensor_ok, temp_out[15:0], hum_out[15:0], stable, responded,
    // probed, budget_spent, zero fill.
    output logic [scs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // tuser: data_valid.
    output logic                              o_m_tuser,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [scs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import scs_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_state  n_state;
    t_result n_result;

    logic    r_in_valid;
    t_item   r_in_item;
    t_state  r_state;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    fire;
    logic    accept;

    // Unpack the incoming transaction.
    assign in_item.now_ms      = i_s_tdata[31:0];
    assign in_item.probe_ok    = i_s_tdata[32];
    assign in_item.sample_nan  = i_s_tuser;
    assign in_item.temp_sample = $signed(i_s_tdata[48:33]);
    assign in_item.raw_hum     = $signed(i_s_tdata[64:49]);

    // The output register is free when empty or drained in this cycle. The staged item
    // is processed whenever its result has a place to go.
    assign out_free   = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    scs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    scs_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_in_item <= in_item;
        end
    end

    // Supervisor state; every field resets to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (fire) begin
            r_out <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.data_valid;
    assign o_m_tdata  = {3'b000, r_out.budget_spent, r_out.probed, r_out.responded,
                         r_out.stable, r_out.hum_out, r_out.temp_out, r_out.sensor_ok};

    // Held data can only be valid while the sensor counts as present.
    a_valid_needs_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.valid |-> r_state.present)
        else $error("valid flag set while sensor absent");

    // The retry and stability counters never pass their limits.
    a_counter_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.retry_count <= MAX_RETRIES_C) && (r_state.stab_count <= STABLE_C))
        else $error("retry or stability counter out of range");

    // A processed item always leaves a result in the output register.
    a_fire_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed item produced no result");

    // A spent budget is only reported for an absent sensor.
    a_budget_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.budget_spent && r_out.sensor_ok))
        else $error("budget spent reported for a present sensor");

endmodule

[hw/rtl/scs_cfg.sv]
// Configuration register file of the sensor channel supervisor.
module scs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output scs_pkg::t_cfg                 o_cfg
);
    import scs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_low   <= TEMP_LOW_RST;
            r_cfg.temp_high  <= TEMP_HIGH_RST;
            r_cfg.hum_low    <= HUM_LOW_RST;
            r_cfg.hum_high   <= HUM_HIGH_RST;
            r_cfg.probe_intv <= PROBE_INTV_RST;
            r_cfg.dead_intv  <= DEAD_INTV_RST;
            r_cfg.temp_ofs   <= OFS_RST;
            r_cfg.hum_ofs    <= OFS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TEMP_LOW:   r_cfg.temp_low   <= $signed(i_cfg_wdata[14:0]);
                CFG_TEMP_HIGH:  r_cfg.temp_high  <= $signed(i_cfg_wdata[14:0]);
                CFG_HUM_LOW:    r_cfg.hum_low    <= i_cfg_wdata[13:0];
                CFG_HUM_HIGH:   r_cfg.hum_high   <= i_cfg_wdata[13:0];
                CFG_PROBE_INTV: r_cfg.probe_intv <= i_cfg_wdata;
                CFG_DEAD_INTV:  r_cfg.dead_intv  <= i_cfg_wdata;
                CFG_TEMP_OFS:   r_cfg.temp_ofs   <= $signed(i_cfg_wdata[11:0]);
                CFG_HUM_OFS:    r_cfg.hum_ofs    <= $signed(i_cfg_wdata[11:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/scs_step.sv]
// Next-state and result logic for one sensor update.
module scs_step (
    input  scs_pkg::t_state  i_state,
    input  scs_pkg::t_item   i_item,
    input  scs_pkg::t_cfg    i_cfg,
    output scs_pkg::t_state  o_state,
    output scs_pkg::t_result o_result
);
    import scs_pkg::*;

    logic               probe_due;
    logic               grant_due;
    logic               in_range;
    logic               good;
    logic [31:0]        probe_age;
    logic [31:0]        grant_age;
    logic signed [15:0] hum_lo_s;
    logic signed [15:0] hum_hi_s;
    logic signed [15:0] temp_lo_s;
    logic signed [15:0] temp_hi_s;
    logic signed [15:0] ema_temp;
    logic signed [15:0] ema_hum;
    logic [2:0]         bad_inc;
    t_state             st;
    logic               responded;

    assign probe_age = i_item.now_ms - i_state.last_probe_time;
    assign grant_age = i_item.now_ms - i_state.last_grant_time;
    assign temp_lo_s = $signed({i_cfg.temp_low[14], i_cfg.temp_low});
    assign temp_hi_s = $signed({i_cfg.temp_high[14], i_cfg.temp_high});
    assign hum_lo_s  = $signed({2'b00, i_cfg.hum_low});
    assign hum_hi_s  = $signed({2'b00, i_cfg.hum_high});
    assign in_range  = (i_item.temp_sample >= temp_lo_s) &&
                       (i_item.temp_sample <= temp_hi_s) &&
                       (i_item.raw_hum >= hum_lo_s) && (i_item.raw_hum <= hum_hi_s);
    assign good      = !i_item.sample_nan && in_range;
    assign ema_temp  = f_ema(i_state.filt_temp, i_item.temp_sample);
    assign ema_hum   = f_ema(i_state.filt_hum, i_item.raw_hum);
    assign probe_due = !i_state.present && (i_state.retry_count < MAX_RETRIES_C) &&
                       (probe_age >= i_cfg.probe_intv);

    always_comb begin
        st        = i_state;
        responded = 1'b0;
        grant_due = 1'b0;
        bad_inc   = i_state.bad_count + 3'd1;

        // Re-probe of an absent sensor.
        if (probe_due) begin
            st.last_probe_time = i_item.now_ms;
            if (i_item.probe_ok) begin
                st.present     = 1'b1;
                st.retry_count = 3'd0;
                st.primed      = 1'b0;
                responded      = 1'b1;
            end else begin
                st.retry_count = i_state.retry_count + 3'd1;
            end
        end

        // Fresh retry budget after the long interval.
        if (!st.present && (st.retry_count >= MAX_RETRIES_C) &&
            (grant_age >= i_cfg.dead_intv)) begin
            grant_due          = 1'b1;
            st.last_grant_time = i_item.now_ms;
            st.retry_count     = 3'd0;
        end

        // Sample check and filtering.
        if (st.present) begin
            if (good) begin
                responded    = 1'b1;
                st.bad_count = 3'd0;
                if (!st.primed) begin
                    st.filt_temp = i_item.temp_sample;
                    st.filt_hum  = i_item.raw_hum;
                    st.primed    = 1'b1;
                end else begin
                    st.filt_temp = ema_temp;
                    st.filt_hum  = ema_hum;
                end
                st.held_temp = f_add_ofs(st.filt_temp, i_cfg.temp_ofs);
                st.held_hum  = f_add_ofs(st.filt_hum, i_cfg.hum_ofs);
                st.valid     = 1'b1;
                if (st.stab_count < STABLE_C) begin
                    st.stab_count = st.stab_count + 4'd1;
                end
            end else if (bad_inc >= MAX_BAD_SAMPLES_C) begin
                st.present     = 1'b0;
                st.retry_count = 3'd0;
                st.stab_count  = 4'd0;
                st.bad_count   = 3'd0;
                st.valid       = 1'b0;
                st.primed      = 1'b0;
            end else begin
                st.bad_count = bad_inc;
                st.valid     = 1'b0;
            end
        end
    end

    assign o_state               = st;
    assign o_result.sensor_ok    = st.present;
    assign o_result.data_valid   = st.valid;
    assign o_result.temp_out     = st.held_temp;
    assign o_result.hum_out      = st.held_hum;
    assign o_result.stable       = (st.stab_count >= STABLE_C);
    assign o_result.responded    = responded;
    assign o_result.probed       = probe_due;
    assign o_result.budget_spent = !st.present && (st.retry_count >= MAX_RETRIES_C) &&
                                   !(grant_due && st.retry_count != 3'd0);

endmodule
